@@ hw/rtl/kvm_pkg.sv @@
// ----------------------------------------------------------------------------
// kvm_pkg: shared types for the key/value map core
// Opcodes, controller states, the search token passed along the cell row and the broadcast write group.
// ----------------------------------------------------------------------------
package kvm_pkg;

  typedef enum logic [2:0] {
    OP_INSERT  = 3'd0,
    OP_UPDATE  = 3'd1,
    OP_INS_UPD = 3'd2,
    OP_ERASE   = 3'd3,
    OP_LOOKUP  = 3'd4,
    OP_READ    = 3'd5
  } kvm_op_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SCAN   = 2'd1,
    ST_FINISH = 2'd2
  } kvm_state_e;

  typedef struct packed {
    logic valid;
    logic found;
  } kvm_tok_t;

  typedef struct packed {
    logic en;
    logic set_key;
    logic set_val;
  } kvm_wr_t;

endpackage

@@ hw/rtl/kvm_cell.sv @@
// ----------------------------------------------------------------------------
// kvm_cell: one entry of the key/value map
// Holds one key/value pair, compares it against the search token as the token
// passes, captures entry data for the token and takes broadcast writes.
// ----------------------------------------------------------------------------
module kvm_cell #(
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32,
  parameter int IDX_W      = 8,
  parameter int CNT_W      = 9,
  parameter int INDEX      = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  kvm_pkg::kvm_op_e      op_i,
  input  logic [KEY_BITS-1:0]   key_i,
  input  logic [7:0]            pos_i,
  input  logic [CNT_W-1:0]      count_i,
  input  kvm_pkg::kvm_tok_t     tok_i,
  input  logic [IDX_W-1:0]      hit_i,
  input  logic [KEY_BITS-1:0]   dk_i,
  input  logic [VALUE_BITS-1:0] dv_i,
  output kvm_pkg::kvm_tok_t     tok_o,
  output logic [IDX_W-1:0]      hit_o,
  output logic [KEY_BITS-1:0]   dk_o,
  output logic [VALUE_BITS-1:0] dv_o,
  input  kvm_pkg::kvm_wr_t      wr_i,
  input  logic [IDX_W-1:0]      wr_addr_i,
  input  logic [KEY_BITS-1:0]   wr_key_i,
  input  logic [VALUE_BITS-1:0] wr_val_i
);

  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  kvm_pkg::kvm_tok_t     tok_q, tok_d;
  logic [IDX_W-1:0]      hit_q, hit_d;
  logic [KEY_BITS-1:0]   dk_q, dk_d;
  logic [VALUE_BITS-1:0] dv_q, dv_d;
  logic                  live;
  logic                  match;
  logic                  is_pos;
  logic                  is_last;
  logic                  cap;
  logic                  wr_hit;

  always_comb begin
    live    = count_i > CNT_W'(INDEX);
    match   = live && (key_q == key_i);
    is_pos  = live && (INDEX == int'(pos_i));
    is_last = count_i == CNT_W'(INDEX + 1);
    unique case (op_i)
      kvm_pkg::OP_LOOKUP: cap = match && !tok_i.found;
      kvm_pkg::OP_READ:   cap = is_pos;
      kvm_pkg::OP_ERASE:  cap = is_last;
      default:            cap = 1'b0;
    endcase
    tok_d.valid = tok_i.valid;
    tok_d.found = tok_i.found | match;
    hit_d       = (match && !tok_i.found) ? IDX_W'(INDEX) : hit_i;
    dk_d        = cap ? key_q : dk_i;
    dv_d        = cap ? val_q : dv_i;
    wr_hit      = wr_i.en && (wr_addr_i == IDX_W'(INDEX));
    key_d       = (wr_hit && wr_i.set_key) ? wr_key_i : key_q;
    val_d       = (wr_hit && wr_i.set_val) ? wr_val_i : val_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q <= hit_d;
    dk_q  <= dk_d;
    dv_q  <= dv_d;
    key_q <= key_d;
    val_q <= val_d;
  end

  assign tok_o = tok_q;
  assign hit_o = hit_q;
  assign dk_o  = dk_q;
  assign dv_o  = dv_q;

endmodule

@@ hw/rtl/fixed_capacity_key_value_map_core.sv @@
// Requests are taken one at a time: in_stall_o stays high until the previous one is done.
// The search token walks the row of CAPACITY entry cells one cell per cycle, then a
// write-back follows, which waits until the output register is free.
// Reset: the entry count clears to zero; stored keys and values are not cleared.
// ----------------------------------------------------------------------------
// fixed_capacity_key_value_map_core: fixed-capacity key/value map
// Unordered table of key/value pairs held in a row of cells, searched linearly
// by a token that shifts through the row; supports insert, update,
// insert-or-update, erase, lookup and read at position.
// ----------------------------------------------------------------------------
module fixed_capacity_key_value_map_core #(
  parameter int CAPACITY   = 256,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  opcode_i,
  input  logic [31:0] key_in_i,
  input  logic [31:0] value_in_i,
  input  logic [7:0]  position_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        ok_o,
  output logic [31:0] key_out_o,
  output logic [31:0] value_out_o,
  output logic [8:0]  entry_count_o
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  kvm_pkg::kvm_state_e   state_q, state_d;
  kvm_pkg::kvm_op_e      op_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [7:0]            pos_q;
  logic                  inj_q;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  res_found_q;
  logic [IDX_W-1:0]      res_hit_q;
  logic [KEY_BITS-1:0]   res_dk_q;
  logic [VALUE_BITS-1:0] res_dv_q;
  logic                  out_valid_q;
  logic                  ok_q, ok_d;
  logic [31:0]           key_out_q, key_out_d;
  logic [31:0]           value_out_q, value_out_d;
  logic [8:0]            entry_count_q;

  kvm_pkg::kvm_tok_t     tok_c [CAPACITY+1];
  logic [IDX_W-1:0]      hit_c [CAPACITY+1];
  logic [KEY_BITS-1:0]   dk_c  [CAPACITY+1];
  logic [VALUE_BITS-1:0] dv_c  [CAPACITY+1];

  kvm_pkg::kvm_wr_t      wr_op, wr_go;
  logic [IDX_W-1:0]      wr_addr;
  logic [KEY_BITS-1:0]   wr_key;
  logic [VALUE_BITS-1:0] wr_val;

  logic                  accept;
  logic                  out_free;
  logic                  finish;
  logic                  full;
  logic                  pos_ok;
  logic                  sel_key;
  logic                  sel_val;
  logic                  append;
  logic [63:0]           key_in_w;
  logic [63:0]           val_in_w;
  logic [63:0]           kout_w;
  logic [63:0]           vout_w;
  logic [15:0]           cnt_w;

  assign in_stall_o = (state_q != kvm_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign key_in_w   = 64'(key_in_i);
  assign val_in_w   = 64'(value_in_i);

  assign tok_c[0] = '{valid: inj_q, found: 1'b0};
  assign hit_c[0] = '0;
  assign dk_c[0]  = '0;
  assign dv_c[0]  = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    kvm_cell #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W),
      .INDEX      (i)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .op_i      (op_q),
      .key_i     (key_q),
      .pos_i     (pos_q),
      .count_i   (count_q),
      .tok_i     (tok_c[i]),
      .hit_i     (hit_c[i]),
      .dk_i      (dk_c[i]),
      .dv_i      (dv_c[i]),
      .tok_o     (tok_c[i+1]),
      .hit_o     (hit_c[i+1]),
      .dk_o      (dk_c[i+1]),
      .dv_o      (dv_c[i+1]),
      .wr_i      (wr_go),
      .wr_addr_i (wr_addr),
      .wr_key_i  (wr_key),
      .wr_val_i  (wr_val)
    );
  end

  always_comb begin
    state_d = state_q;
    finish  = 1'b0;
    unique case (state_q)
      kvm_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = kvm_pkg::ST_SCAN;
      end
      kvm_pkg::ST_SCAN: begin
        if (tok_c[CAPACITY].valid) state_d = kvm_pkg::ST_FINISH;
      end
      kvm_pkg::ST_FINISH: begin
        if (out_free) begin
          finish  = 1'b1;
          state_d = kvm_pkg::ST_IDLE;
        end
      end
      default: state_d = kvm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    full    = (count_q == CNT_W'(CAPACITY));
    pos_ok  = 16'(pos_q) < 16'(count_q);
    ok_d    = 1'b0;
    sel_key = 1'b0;
    sel_val = 1'b0;
    append  = 1'b0;
    count_d = count_q;
    wr_op   = '0;
    wr_addr = res_hit_q;
    wr_key  = key_q;
    wr_val  = val_q;
    unique case (op_q)
      kvm_pkg::OP_INSERT: begin
        append = !res_found_q && !full;
      end
      kvm_pkg::OP_UPDATE: begin
        ok_d  = res_found_q;
        wr_op = '{en: res_found_q, set_key: 1'b0, set_val: 1'b1};
      end
      kvm_pkg::OP_INS_UPD: begin
        if (res_found_q) begin
          ok_d  = 1'b1;
          wr_op = '{en: 1'b1, set_key: 1'b0, set_val: 1'b1};
        end else begin
          append = !full;
        end
      end
      kvm_pkg::OP_ERASE: begin
        ok_d   = res_found_q;
        wr_op  = '{en: res_found_q, set_key: 1'b1, set_val: 1'b1};
        wr_key = res_dk_q;
        wr_val = res_dv_q;
        if (res_found_q) count_d = count_q - CNT_W'(1);
      end
      kvm_pkg::OP_LOOKUP: begin
        ok_d    = res_found_q;
        sel_val = res_found_q;
      end
      kvm_pkg::OP_READ: begin
        ok_d    = pos_ok;
        sel_key = pos_ok;
        sel_val = pos_ok;
      end
      default: ok_d = 1'b0;
    endcase
    if (append) begin
      ok_d    = 1'b1;
      wr_op   = '{en: 1'b1, set_key: 1'b1, set_val: 1'b1};
      wr_addr = count_q[IDX_W-1:0];
      count_d = count_q + CNT_W'(1);
    end
    wr_go       = '{en: wr_op.en & finish, set_key: wr_op.set_key, set_val: wr_op.set_val};
    kout_w      = 64'(res_dk_q);
    vout_w      = 64'(res_dv_q);
    key_out_d   = sel_key ? kout_w[31:0] : '0;
    value_out_d = sel_val ? vout_w[31:0] : '0;
    cnt_w       = 16'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kvm_pkg::ST_IDLE;
      inj_q       <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      inj_q   <= accept;
      if (finish) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= kvm_pkg::kvm_op_e'(opcode_i);
      key_q <= key_in_w[KEY_BITS-1:0];
      val_q <= val_in_w[VALUE_BITS-1:0];
      pos_q <= position_i;
    end
    if (state_q == kvm_pkg::ST_SCAN && tok_c[CAPACITY].valid) begin
      res_found_q <= tok_c[CAPACITY].found;
      res_hit_q   <= hit_c[CAPACITY];
      res_dk_q    <= dk_c[CAPACITY];
      res_dv_q    <= dv_c[CAPACITY];
    end
    if (finish) begin
      ok_q          <= ok_d;
      key_out_q     <= key_out_d;
      value_out_q   <= value_out_d;
      entry_count_q <= cnt_w[8:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ok_o          = ok_q;
  assign key_out_o     = key_out_q;
  assign value_out_o   = value_out_q;
  assign entry_count_o = entry_count_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_token_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_c[CAPACITY].valid |-> state_q == kvm_pkg::ST_SCAN)
    else $error("search token left the row outside a scan");

  a_idle_row_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == kvm_pkg::ST_IDLE |-> !inj_q && !tok_c[CAPACITY].valid)
    else $error("token in flight while idle");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish && op_q == kvm_pkg::OP_INSERT && ok_d |=>
      count_q == $past(count_q) + CNT_W'(1))
    else $error("successful insert did not grow the table");

  a_write_in_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_go.en |-> state_q == kvm_pkg::ST_FINISH && out_free)
    else $error("entry write outside write-back");
`endif

endmodule

@@ verif/kvm_map_sb_pkg.sv @@
// ----------------------------------------------------------------------------
// kvm_map_sb_pkg: scoreboard for the key/value map core
// Keeps a shadow copy of the key and value stores and the entry count. For
// every accepted request it queues the reply that the map must give, and it
// compares each returned reply, field by field, with the oldest queued one.
// ----------------------------------------------------------------------------
package kvm_map_sb_pkg;
  import kvm_pkg::*;

  localparam int MAP_DEPTH = 256;

  typedef struct {
    logic        ok;
    logic [31:0] key;
    logic [31:0] value;
    logic [8:0]  count;
  } kvm_reply_t;

  class kv_map_scoreboard;
    logic [31:0] keys [MAP_DEPTH];
    logic [31:0] vals [MAP_DEPTH];
    int unsigned used;
    kvm_reply_t  awaited [$];
    int unsigned errors;

    function new();
      used   = 0;
      errors = 0;
    endfunction

    function int unsigned size();
      return used;
    endfunction

    function logic [31:0] key_at(int unsigned idx);
      return keys[idx];
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    // lowest live slot holding k, or -1
    function int find_slot(logic [31:0] k);
      for (int i = 0; i < int'(used); i++) begin
        if (keys[i] == k) return i;
      end
      return -1;
    endfunction

    function bit append_pair(logic [31:0] k, logic [31:0] v);
      if (used >= MAP_DEPTH) return 1'b0;
      keys[used] = k;
      vals[used] = v;
      used++;
      return 1'b1;
    endfunction

    function void note_request(logic [2:0] op, logic [31:0] k, logic [31:0] v,
                               logic [7:0] pos);
      kvm_reply_t r;
      int         hit;
      r.ok    = 1'b0;
      r.key   = '0;
      r.value = '0;
      hit     = find_slot(k);
      case (op)
        OP_INSERT: begin
          if (hit < 0) r.ok = append_pair(k, v);
        end
        OP_UPDATE: begin
          if (hit >= 0) begin
            vals[hit] = v;
            r.ok      = 1'b1;
          end
        end
        OP_INS_UPD: begin
          if (hit >= 0) begin
            vals[hit] = v;
            r.ok      = 1'b1;
          end else begin
            r.ok = append_pair(k, v);
          end
        end
        OP_ERASE: begin
          // move the last entry into the freed slot
          if (hit >= 0) begin
            keys[hit] = keys[used-1];
            vals[hit] = vals[used-1];
            used--;
            r.ok = 1'b1;
          end
        end
        OP_LOOKUP: begin
          if (hit >= 0) begin
            r.value = vals[hit];
            r.ok    = 1'b1;
          end
        end
        OP_READ: begin
          if (pos < used) begin
            r.key   = keys[pos];
            r.value = vals[pos];
            r.ok    = 1'b1;
          end
        end
        default: begin
        end
      endcase
      r.count = 9'(used);
      awaited.push_back(r);
    endfunction

    function void check_reply(logic ok, logic [31:0] k, logic [31:0] v, logic [8:0] cnt);
      kvm_reply_t e;
      if (awaited.size() == 0) begin
        $error("reply with no request outstanding: ok=%0b key=%h value=%h count=%0d",
               ok, k, v, cnt);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (ok !== e.ok) begin
        $error("ok: expected %0b, got %0b", e.ok, ok);
        errors++;
      end
      if (k !== e.key) begin
        $error("key_out: expected %h, got %h", e.key, k);
        errors++;
      end
      if (v !== e.value) begin
        $error("value_out: expected %h, got %h", e.value, v);
        errors++;
      end
      if (cnt !== e.count) begin
        $error("entry_count: expected %0d, got %0d", e.count, cnt);
        errors++;
      end
    endfunction
  endclass

endpackage

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench for fixed_capacity_key_value_map_core
// Drives directed requests for the empty, present, absent and out-of-range
// cases, then random traffic that grows the table, fills it to capacity and
// then removes entries, with random gaps on the request side and random stalls on
// the reply side. Every reply is checked against the scoreboard.
// ----------------------------------------------------------------------------
module tb_top;
  import kvm_pkg::*;
  import kvm_map_sb_pkg::*;

  localparam int          CAP       = MAP_DEPTH;
  localparam int unsigned CYCLE_CAP = 4_000_000;
  localparam logic [2:0]  OP_SPARE6 = 3'd6;
  localparam logic [2:0]  OP_SPARE7 = 3'd7;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [2:0]  opcode_i    = '0;
  logic [31:0] key_in_i    = '0;
  logic [31:0] value_in_i  = '0;
  logic [7:0]  position_i  = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        ok_o;
  logic [31:0] key_out_o;
  logic [31:0] value_out_o;
  logic [8:0]  entry_count_o;

  int unsigned cycles     = 0;
  int unsigned stall_left = 0;
  logic [31:0] hot_keys [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
                                32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_00FF, 32'h1234_5678};

  kv_map_scoreboard sb = new();

  fixed_capacity_key_value_map_core i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .opcode_i,
    .key_in_i,
    .value_in_i,
    .position_i,
    .out_valid_o,
    .out_stall_i,
    .ok_o,
    .key_out_o,
    .value_out_o,
    .entry_count_o
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_CAP) begin
      $display("[fixed_capacity_key_value_map_core] ERROR");
      $finish;
    end
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(30, 400);
  endfunction

  function automatic int unsigned stall_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 20);
    return $urandom_range(50, 500);
  endfunction

  // set the reply stall at random, in runs of random length
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      out_stall_i <= 1'($urandom_range(0, 1));
      stall_left  <= stall_len();
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_reply(ok_o, key_out_o, value_out_o, entry_count_o);
    end
  end

  function automatic logic [31:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50 && sb.size() > 0) return sb.key_at($urandom_range(0, sb.size() - 1));
    if (r < 70) return hot_keys[$urandom_range(0, 7)];
    return $urandom();
  endfunction

  function automatic logic [7:0] pick_pos();
    int unsigned lim;
    lim = (sb.size() > 255) ? 255 : sb.size();
    if ($urandom_range(0, 9) < 7) return 8'($urandom_range(0, lim));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_req(logic [2:0] op, logic [31:0] k, logic [31:0] v, logic [7:0] pos);
    int unsigned gap;
    gap = idle_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    key_in_i   <= k;
    value_in_i <= v;
    position_i <= pos;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(op, k, v, pos);
  endtask

  task automatic mixed_traffic(int unsigned n, int unsigned erase_pct);
    logic [2:0]  op;
    int unsigned r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < erase_pct) op = OP_ERASE;
      else if (r < erase_pct + 4) op = $urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7;
      else op = 3'($urandom_range(OP_INSERT, OP_READ));
      send_req(op, pick_key(), $urandom(), pick_pos());
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table
    send_req(OP_LOOKUP, 32'h0, 32'h0, 8'd0);
    send_req(OP_READ, 32'h0, 32'h0, 8'd0);
    send_req(OP_ERASE, 32'hFFFF_FFFF, 32'h0, 8'd0);
    send_req(OP_UPDATE, 32'h0, 32'hFFFF_FFFF, 8'd0);
    // extremes, duplicate insert, update paths
    send_req(OP_INSERT, 32'h0, 32'hFFFF_FFFF, 8'hFF);
    send_req(OP_INSERT, 32'hFFFF_FFFF, 32'h0, 8'd0);
    send_req(OP_INSERT, 32'h0, 32'h1111_1111, 8'd0);
    send_req(OP_UPDATE, 32'h0, 32'h1234_5678, 8'd0);
    send_req(OP_INS_UPD, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 8'd0);
    send_req(OP_INS_UPD, 32'h5A5A_5A5A, 32'h8000_0001, 8'd0);
    send_req(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 8'd0);
    send_req(OP_READ, 32'h0, 32'h0, 8'd0);
    send_req(OP_READ, 32'h0, 32'h0, 8'd1);
    send_req(OP_READ, 32'h0, 32'h0, 8'd2);
    send_req(OP_READ, 32'h0, 32'h0, 8'd3);
    send_req(OP_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    // erase first slot, then the entry moved into it
    send_req(OP_ERASE, 32'h0, 32'h0, 8'd0);
    send_req(OP_READ, 32'h0, 32'h0, 8'd0);
    send_req(OP_LOOKUP, 32'h0, 32'h0, 8'd0);
    send_req(OP_ERASE, 32'h5A5A_5A5A, 32'h0, 8'd0);
    send_req(OP_ERASE, 32'h5A5A_5A5A, 32'h0, 8'd0);
    send_req(OP_SPARE6, $urandom(), $urandom(), 8'($urandom()));
    send_req(OP_SPARE7, $urandom(), $urandom(), 8'($urandom()));

    mixed_traffic(80, 10);

    // fill to capacity
    while (sb.size() < CAP) begin
      if ($urandom_range(0, 9) == 0) begin
        send_req($urandom_range(0, 1) ? OP_LOOKUP : OP_READ, pick_key(), $urandom(),
                 pick_pos());
      end else begin
        send_req($urandom_range(0, 1) ? OP_INSERT : OP_INS_UPD, $urandom(), $urandom(),
                 pick_pos());
      end
    end

    // full table
    send_req(OP_INSERT, $urandom(), $urandom(), 8'd0);
    send_req(OP_INSERT, sb.key_at(7), $urandom(), 8'd0);
    send_req(OP_INS_UPD, $urandom(), $urandom(), 8'd0);
    send_req(OP_INS_UPD, sb.key_at(CAP - 1), $urandom(), 8'd0);
    send_req(OP_READ, 32'h0, 32'h0, 8'hFF);
    send_req(OP_LOOKUP, sb.key_at(CAP - 1), 32'h0, 8'd0);
    send_req(OP_ERASE, sb.key_at(0), 32'h0, 8'd0);
    send_req(OP_READ, 32'h0, 32'h0, 8'd0);
    send_req(OP_INSERT, $urandom(), $urandom(), 8'd0);

    mixed_traffic(90, 35);

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (CAP + 8) @(posedge clk_i);

    if (sb.pending() != 0) begin
      $error("%0d replies never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("[fixed_capacity_key_value_map_core] OK");
    end else begin
      $display("[fixed_capacity_key_value_map_core] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/kvm_pkg.sv
hw/rtl/kvm_cell.sv
hw/rtl/fixed_capacity_key_value_map_core.sv
verif/kvm_map_sb_pkg.sv
verif/tb_top.sv
